// ===== hdl/lz77d_pkg.sv =====
package lz77d_pkg;

	localparam int HISTORY_DEPTH = 4096;
	localparam int MAX_MATCH     = 15;

	localparam int DIST_W = 12;
	localparam int LEN_W  = 4;
	localparam int BYTE_W = 8;
	localparam int PTR_W  = $clog2(HISTORY_DEPTH);
	localparam int CNT_W  = $clog2(HISTORY_DEPTH + 1);

	typedef logic [DIST_W-1:0] dist_t;
	typedef logic [LEN_W-1:0]  len_t;
	typedef logic [BYTE_W-1:0] byte_t;
	typedef logic [PTR_W-1:0]  ptr_t;
	typedef logic [CNT_W-1:0]  cnt_t;

	typedef struct packed {
		logic in_ready;
		logic load;
		logic emit_copy;
		logic emit_lit;
	} ctl_cmd_t;

	typedef struct packed {
		logic in_valid;
		logic len_zero;
		logic copy_last;
		logic out_free;
	} dp_sts_t;

endpackage

// ===== hdl/lz77d_ifs.sv =====
interface lz77d_token_if;
	import lz77d_pkg::*;

	logic  valid;
	logic  ready;
	dist_t distance;
	len_t  match_length;
	byte_t literal;

	modport source (output valid, distance, match_length, literal, input ready);
	modport sink (input valid, distance, match_length, literal, output ready);
endinterface

interface lz77d_byte_if;
	import lz77d_pkg::*;

	logic  valid;
	logic  ready;
	byte_t out_byte;
	logic  last_of_token;
	logic  bad_distance;

	modport source (output valid, out_byte, last_of_token, bad_distance, input ready);
	modport sink (input valid, out_byte, last_of_token, bad_distance, output ready);
endinterface

// ===== hdl/lz77_token_decoder.sv =====
// Channel  Role    Payload                              Meaning
// token    sink    distance, match_length, literal      one LZ77 token per transfer
// result   source  out_byte, last_of_token, bad_distance one output byte per transfer
//
// A token is loaded, then emits its copied bytes (match_length, clamped to 15) and its
// literal: 1 to 16 bytes, one byte per cycle while the result is not stalled.
// A new token is taken only after the previous token's literal has left the engine;
// the output register lets it wait for the sink while the next token loads.
// A stalled result holds the engine; no byte is lost or repeated.
// Reset clears the write pointer, the produced count and all valid state; the history
// RAM is not cleared, since only bytes already produced are ever read back.
module lz77_token_decoder
	import lz77d_pkg::*;
(
	input logic          clk,
	input logic          arst_n,
	lz77d_token_if.sink  token,
	lz77d_byte_if.source result
);

	ctl_cmd_t cmd;
	dp_sts_t  sts;

	lz77d_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.sts    (sts),
		.cmd    (cmd)
	);

	lz77d_datapath u_datapath (
		.clk    (clk),
		.arst_n (arst_n),
		.token  (token),
		.result (result),
		.cmd    (cmd),
		.sts    (sts)
	);

endmodule

// ===== hdl/lz77d_ctrl.sv =====
module lz77d_ctrl
	import lz77d_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  dp_sts_t  sts,
	output ctl_cmd_t cmd
);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_COPY = 2'd1;
	localparam logic [1:0] ST_LIT  = 2'd2;

	logic [1:0] state_q;
	logic [1:0] state_d;

	always_comb begin
		cmd.in_ready  = (state_q == ST_IDLE);
		cmd.load      = (state_q == ST_IDLE) && sts.in_valid;
		cmd.emit_copy = (state_q == ST_COPY) && sts.out_free;
		cmd.emit_lit  = (state_q == ST_LIT) && sts.out_free;
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (sts.in_valid) begin
					state_d = sts.len_zero ? ST_LIT : ST_COPY;
				end
			end
			ST_COPY: begin
				if (sts.out_free && sts.copy_last) begin
					state_d = ST_LIT;
				end
			end
			ST_LIT: begin
				if (sts.out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

// ===== hdl/lz77d_datapath.sv =====
module lz77d_datapath
	import lz77d_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	lz77d_token_if.sink        token,
	lz77d_byte_if.source       result,
	input  ctl_cmd_t           cmd,
	output dp_sts_t            sts
);

	byte_t history_mem [HISTORY_DEPTH];

	ptr_t  wp_q;
	cnt_t  produced_q;
	dist_t dist_q;
	byte_t lit_q;
	len_t  cnt_q;
	logic  bad_q;

	byte_t rd_data_q;
	logic  fwd_q;
	byte_t fwd_byte_q;

	logic  out_valid_q;
	byte_t out_byte_q;
	logic  last_q;
	logic  bad_out_q;

	logic  emit;
	byte_t emit_byte;
	byte_t hist_byte;
	ptr_t  wp_next;
	ptr_t  rd_addr;
	dist_t dist_sel;
	len_t  len_clamped;
	logic  bad_new;

	assign token.ready = cmd.in_ready;

	assign len_clamped = (token.match_length > len_t'(MAX_MATCH))
		? len_t'(MAX_MATCH) : token.match_length;
	assign bad_new = (len_clamped != '0)
		&& ((token.distance == '0) || (cnt_t'(token.distance) > produced_q));

	assign emit      = cmd.emit_copy || cmd.emit_lit;
	assign hist_byte = fwd_q ? fwd_byte_q : rd_data_q;
	assign emit_byte = cmd.emit_lit ? lit_q : (bad_q ? '0 : hist_byte);

	// The read always targets the byte needed in the next cycle, so a copy
	// runs at one byte per cycle unless the result stalls. A read of the slot
	// being written this cycle (distance one) takes the written byte instead.
	assign wp_next  = wp_q + ptr_t'(emit);
	assign dist_sel = cmd.load ? token.distance : dist_q;
	assign rd_addr  = wp_next - ptr_t'(dist_sel);

	always_comb begin
		sts.in_valid  = token.valid;
		sts.len_zero  = (len_clamped == '0);
		sts.copy_last = (cnt_q == len_t'(1));
		sts.out_free  = !out_valid_q || result.ready;
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			history_mem[wp_q] <= emit_byte;
		end
		rd_data_q  <= history_mem[rd_addr];
		fwd_q      <= emit && (rd_addr == wp_q);
		fwd_byte_q <= emit_byte;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q        <= '0;
			produced_q  <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (emit) begin
				wp_q <= wp_next;
				if (produced_q != cnt_t'(HISTORY_DEPTH)) begin
					produced_q <= produced_q + cnt_t'(1);
				end
				out_valid_q <= 1'b1;
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			dist_q <= token.distance;
			lit_q  <= token.literal;
			cnt_q  <= len_clamped;
			bad_q  <= bad_new;
		end else if (cmd.emit_copy) begin
			cnt_q <= cnt_q - len_t'(1);
		end
		if (emit) begin
			out_byte_q <= emit_byte;
			last_q     <= cmd.emit_lit;
			bad_out_q  <= bad_q;
		end
	end

	assign result.valid         = out_valid_q;
	assign result.out_byte      = out_byte_q;
	assign result.last_of_token = last_q;
	assign result.bad_distance  = bad_out_q;

	a_no_double_emit: assert property (@(posedge clk) disable iff (!arst_n)
		!(cmd.emit_copy && cmd.emit_lit))
		else $error("copy and literal emitted in the same cycle");

	a_emit_needs_room: assert property (@(posedge clk) disable iff (!arst_n)
		emit |-> (!out_valid_q || result.ready))
		else $error("byte emitted over an untaken result");

	a_lit_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit_lit |=> (result.valid && result.last_of_token))
		else $error("literal not presented as the last byte of its token");

	a_bad_copy_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.emit_copy && bad_q) |=> (result.out_byte == '0 && result.bad_distance))
		else $error("flagged copy produced a nonzero byte");

	a_count_saturates: assert property (@(posedge clk) disable iff (!arst_n)
		produced_q <= cnt_t'(HISTORY_DEPTH))
		else $error("produced count passed the history depth");

endmodule
